>>> src/kitt_pkg.sv
// ----------------------------------------------------------------------------
// kitt_pkg
// shared types, codes and widths for the keyed inactivity timeout table
// ----------------------------------------------------------------------------
package kitt_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int KEY_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int TIMEOUT_W = 16;
    localparam int COUNT_W   = 32;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_USE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNUSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic start;   // take the input item
        logic step;    // evaluate the current entry and move on
        logic finish;  // emit the final result and commit the update
    } kitt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic nop;        // input item carries the unused command code
        logic skip_scan;  // input tick with expiry disabled
        logic hit;        // lookup matched the current entry
        logic at_end;     // current entry is the last one
        logic need_push;  // current entry expires while another is pending
        logic out_free;   // output register can take a result this cycle
    } kitt_stat_t;

endpackage

>>> src/kitt_ctrl.sv
// ----------------------------------------------------------------------------
// kitt_ctrl
// sequencer for accept, table scan and final result of each item
// ----------------------------------------------------------------------------
module kitt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kitt_pkg::kitt_stat_t stat,
    output kitt_pkg::kitt_cmd_t  ctl
);
    import kitt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.start = 1'b1;
                    priority if (stat.nop)
                        state_next = S_IDLE;
                    else if (stat.skip_scan)
                        state_next = S_FINISH;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // hold while an earlier expiry cannot be handed out yet
                if (!(stat.need_push && !stat.out_free))
                begin
                    ctl.step = 1'b1;
                    if (stat.hit || stat.at_end)
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/kitt_dp.sv
// ----------------------------------------------------------------------------
// kitt_dp
// key and stamp memories, valid bits, tick counter, scan state and output register
// ----------------------------------------------------------------------------
module kitt_dp #(
    parameter int TABLE_ENTRIES = kitt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [kitt_pkg::CMD_W-1:0]        cmd,
    input  logic [kitt_pkg::KEY_W-1:0]        key,
    input  logic                              cfg_wr_en,
    input  logic [kitt_pkg::TIMEOUT_W-1:0]    cfg_wr_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [kitt_pkg::STATUS_W-1:0]     status,
    output logic [kitt_pkg::KEY_W-1:0]        result_key,
    output logic                              last,
    input  kitt_pkg::kitt_cmd_t               ctl,
    output kitt_pkg::kitt_stat_t              stat
);
    import kitt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // memories
    logic [KEY_W-1:0]   key_mem   [TABLE_ENTRIES];
    logic [COUNT_W-1:0] stamp_mem [TABLE_ENTRIES];
    logic [KEY_W-1:0]   rd_key_reg;
    logic [COUNT_W-1:0] rd_stamp_reg;

    logic               mem_key_we;
    logic               mem_stamp_we;
    logic [IDX_W-1:0]   mem_waddr;

    // control and scan state
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [COUNT_W-1:0]       now_reg, now_next;
    logic [TIMEOUT_W-1:0]     timeout_reg;
    logic                     hit_reg, hit_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0]         pend_key_reg, pend_key_next;

    // latched item
    logic [CMD_W-1:0]         cmd_reg;
    logic [KEY_W-1:0]         key_reg;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [KEY_W-1:0]         rkey_reg, rkey_next;
    logic                     last_reg, last_next;
    logic                     out_load;

    logic                     is_tick;
    logic                     cur_valid;
    logic                     cur_hit;
    logic                     cur_exp;
    logic [COUNT_W-1:0]       age;

    assign is_tick   = (cmd_reg == CMD_TICK);
    assign cur_valid = valid_reg[idx_reg];
    assign cur_hit   = !is_tick && cur_valid && (rd_key_reg == key_reg);
    assign age       = now_reg - rd_stamp_reg;
    assign cur_exp   = is_tick && cur_valid && (age >= COUNT_W'(timeout_reg));

    assign stat.nop       = (cmd == CMD_NONE);
    assign stat.skip_scan = (cmd == CMD_TICK) && (timeout_reg == '0);
    assign stat.hit       = cur_hit;
    assign stat.at_end    = (idx_reg == IDX_LAST);
    assign stat.need_push = cur_exp && pend_valid_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        idx_next        = idx_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        out_load        = 1'b0;
        status_next     = status_reg;
        rkey_next       = rkey_reg;
        last_next       = last_reg;
        mem_key_we      = 1'b0;
        mem_stamp_we    = 1'b0;
        mem_waddr       = hit_idx_reg;

        if (ctl.start)
        begin
            idx_next        = '0;
            hit_next        = 1'b0;
            free_found_next = 1'b0;
            pend_valid_next = 1'b0;
            if (cmd == CMD_TICK)
                now_next = now_reg + 1'b1;
        end

        if (ctl.step)
        begin
            if (!stat.at_end)
                idx_next = idx_reg + 1'b1;
            if (cur_hit)
            begin
                hit_next     = 1'b1;
                hit_idx_next = idx_reg;
            end
            if (!is_tick && !cur_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx_reg;
            end
            if (cur_exp)
            begin
                valid_next[idx_reg] = 1'b0;
                pend_valid_next     = 1'b1;
                pend_key_next       = rd_key_reg;
                // previous expiry goes out, it is not the final one
                if (pend_valid_reg)
                begin
                    out_load    = 1'b1;
                    status_next = ST_EXPIRED;
                    rkey_next   = pend_key_reg;
                    last_next   = 1'b0;
                end
            end
        end

        if (ctl.finish)
        begin
            out_load  = 1'b1;
            last_next = 1'b1;
            rkey_next = key_reg;
            unique case (cmd_reg)
                CMD_USE:
                begin
                    if (hit_reg)
                    begin
                        status_next  = ST_REFRESHED;
                        mem_stamp_we = 1'b1;
                        mem_waddr    = hit_idx_reg;
                    end
                    else if (free_found_reg)
                    begin
                        status_next              = ST_ADDED;
                        mem_stamp_we             = 1'b1;
                        mem_key_we               = 1'b1;
                        mem_waddr                = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                CMD_UNUSE:
                begin
                    if (hit_reg)
                    begin
                        status_next             = ST_REFRESHED;
                        valid_next[hit_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                    end
                end
                CMD_TICK:
                begin
                    if (pend_valid_reg)
                    begin
                        status_next = ST_EXPIRED;
                        rkey_next   = pend_key_reg;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                        rkey_next   = '0;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // read address is taken from idx_next so the registered read data always matches idx_reg
    always_ff @(posedge clk)
    begin
        if (mem_key_we)
            key_mem[mem_waddr] <= key_reg;
        if (mem_stamp_we)
            stamp_mem[mem_waddr] <= now_reg;
        rd_key_reg   <= key_mem[idx_next];
        rd_stamp_reg <= stamp_mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            now_reg        <= '0;
            timeout_reg    <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            now_reg        <= now_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
        end
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        pend_key_reg <= pend_key_next;
        status_reg   <= status_next;
        rkey_reg     <= rkey_next;
        last_reg     <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign result_key = rkey_reg;
    assign last       = last_reg;

endmodule

>>> src/keyed_inactivity_timeout_table.sv
// ----------------------------------------------------------------------------
// keyed_inactivity_timeout_table: use/unuse key table with tick-driven expiry
// use/unuse: one entry scanned per cycle, early stop on a key match; the next
//   item is taken only after the result of the last one is loaded
// tick: scans every entry, stalls on output backpressure; no scan if timeout is 0
// reset clears valid bits, tick counter and timeout; no memory clearing pass
// ----------------------------------------------------------------------------
module keyed_inactivity_timeout_table #(
    parameter int TABLE_ENTRIES = kitt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [kitt_pkg::CMD_W-1:0]     cmd,
    input  logic [kitt_pkg::KEY_W-1:0]     key,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [kitt_pkg::STATUS_W-1:0]  status,
    output logic [kitt_pkg::KEY_W-1:0]     result_key,
    output logic                           last,
    // timeout register write
    input  logic                           cfg_wr_en,
    input  logic [kitt_pkg::TIMEOUT_W-1:0] cfg_wr_data
);
    import kitt_pkg::*;

    // the scan walks the key and stamp memories one entry per cycle unless
    // stalled; the memory read port paces both lookups and ticks
    //
    // lookup items keep the lowest free slot seen so a new key can be
    // placed without a second pass
    //
    // expiries on a tick are held one deep so the final one can carry
    // last; the scan stalls only while the output register is still full

    kitt_cmd_t  ctl;
    kitt_stat_t stat;

    // sequencer: idle, scan, finish
    kitt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // table storage, counter and result register
    kitt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key         (key),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .result_key  (result_key),
        .last        (last),
        .ctl         (ctl),
        .stat        (stat)
    );

endmodule

>>> tb/keyed_inactivity_timeout_table_tb.sv
// ----------------------------------------------------------------------------
// keyed_inactivity_timeout_table_tb
// drives use, unuse and tick items into the key table under several timeout
// settings and checks every result item against a cycle-free table model
// ----------------------------------------------------------------------------
module keyed_inactivity_timeout_table_tb;

    import kitt_pkg::*;

    localparam int ENTRIES      = TABLE_ENTRIES_DEF;
    localparam int KEY_POOL     = 36;             // a few more keys than entries
    localparam int DRAIN_CYCLES = ENTRIES + 8;    // worst scan plus margin
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_PHASES   = 5;

    // one result item as the table should report it
    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [KEY_W-1:0]    rkey;
        logic                fin;
    } outcome_t;

    // directed row: a timeout write, or an item with an optional typed result
    typedef struct packed {
        logic                is_cfg;
        logic [CMD_W-1:0]    op;
        logic [KEY_W-1:0]    k;     // item key, or timeout value on a write
        logic                typed;
        logic [STATUS_W-1:0] st;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd = CMD_USE;
    logic [KEY_W-1:0]     key = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [KEY_W-1:0]     result_key;
    logic                 last;
    logic                 cfg_wr_en = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wr_data = '0;

    // shadow copy of the table, counter and timeout
    logic                 tbl_valid [ENTRIES];
    logic [KEY_W-1:0]     tbl_key   [ENTRIES];
    logic [COUNT_W-1:0]   tbl_stamp [ENTRIES];
    logic [COUNT_W-1:0]   tick_count = '0;
    logic [TIMEOUT_W-1:0] idle_limit = '0;

    outcome_t             pending_outcomes [$];
    logic [KEY_W-1:0]     key_pool [KEY_POOL];

    bit                   idle_on = 1'b1;
    int                   stall_left = 0;
    int                   cycle_cnt = 0;
    int                   err_cnt = 0;
    int                   items_sent = 0;
    int                   results_seen = 0;
    int                   expired_seen = 0;
    int                   full_seen = 0;
    int                   fill_idx = 0;

    keyed_inactivity_timeout_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .result_key  (result_key),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 clk = ~clk;

    // safety net against a hung handshake
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit hit, %0d results still pending", $time,
                     pending_outcomes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side backpressure: random bursts of stalls
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // result checker: each accepted result against the oldest outcome
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (status == ST_EXPIRED)
                expired_seen <= expired_seen + 1;
            if (status == ST_FULL)
                full_seen <= full_seen + 1;
            if (pending_outcomes.size() == 0)
            begin
                err_cnt <= err_cnt + 1;
                $display("%0t: unexpected result, got status %0d key %h last %0b",
                         $time, status, result_key, last);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.st)
                begin
                    err_cnt <= err_cnt + 1;
                    $display("%0t: status mismatch, expected %0d, got %0d (key %h)",
                             $time, want.st, status, want.rkey);
                end
                if (result_key !== want.rkey)
                begin
                    err_cnt <= err_cnt + 1;
                    $display("%0t: result_key mismatch, expected %h, got %h",
                             $time, want.rkey, result_key);
                end
                if (last !== want.fin)
                begin
                    err_cnt <= err_cnt + 1;
                    $display("%0t: last mismatch, expected %0b, got %0b (key %h)",
                             $time, want.fin, last, want.rkey);
                end
            end
        end
    end

    // table behavior for one accepted item; fills res with the results it causes
    task automatic table_step(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                              ref outcome_t res[$]);
        int hit;
        int free_slot;
        logic [COUNT_W-1:0] idle;
        hit = -1;
        free_slot = -1;
        res.delete();
        // key lookup and lowest free entry
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (tbl_valid[i] && tbl_key[i] == k)
                hit = i;
            if (!tbl_valid[i])
                free_slot = i;
        end
        case (op)
            CMD_USE:
            begin
                if (hit >= 0)
                begin
                    tbl_stamp[hit] = tick_count;
                    res.push_back('{ST_REFRESHED, k, 1'b1});
                end
                else if (free_slot >= 0)
                begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_key[free_slot]   = k;
                    tbl_stamp[free_slot] = tick_count;
                    res.push_back('{ST_ADDED, k, 1'b1});
                end
                else
                    res.push_back('{ST_FULL, k, 1'b1});
            end
            CMD_UNUSE:
            begin
                if (hit >= 0)
                begin
                    tbl_valid[hit] = 1'b0;
                    res.push_back('{ST_REFRESHED, k, 1'b1});
                end
                else
                    res.push_back('{ST_NOTFOUND, k, 1'b1});
            end
            CMD_TICK:
            begin
                tick_count = tick_count + 1;
                // scan in index order, idle time wraps with the counter
                if (idle_limit != 0)
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        idle = tick_count - tbl_stamp[i];
                        if (tbl_valid[i] && idle >= COUNT_W'(idle_limit))
                        begin
                            res.push_back('{ST_EXPIRED, tbl_key[i], 1'b0});
                            tbl_valid[i] = 1'b0;
                        end
                    end
                if (res.size() == 0)
                    res.push_back('{ST_DONE, '0, 1'b1});
                else
                    res[res.size() - 1].fin = 1'b1;
            end
            default: ;  // unused code, no result
        endcase
    endtask

    // present one item, hold it until taken, then record what it should cause
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic typed, input logic [STATUS_W-1:0] st);
        outcome_t res[$];
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        table_step(op, k, res);
        if (typed)
            pending_outcomes.push_back('{st, (st == ST_DONE) ? '0 : k, 1'b1});
        else
            foreach (res[i])
                pending_outcomes.push_back(res[i]);
        items_sent++;
    endtask

    // let every expected result drain, plus the worst scan that emits nothing
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        idle_limit = v;
    endtask

    // directed rows, starting from reset with expiry disabled
    row_t dir_rows [21] = '{
        '{1'b0, CMD_UNUSE, 32'h0000_0000, 1'b1, ST_NOTFOUND},   // empty table
        '{1'b0, CMD_USE,   32'h0000_0000, 1'b1, ST_ADDED},
        '{1'b0, CMD_USE,   32'hFFFF_FFFF, 1'b1, ST_ADDED},
        '{1'b0, CMD_USE,   32'h0000_0000, 1'b1, ST_REFRESHED},
        '{1'b0, CMD_TICK,  32'hFFFF_FFFF, 1'b1, ST_DONE},       // timeout zero
        '{1'b0, CMD_NONE,  32'hA5A5_A5A5, 1'b0, ST_DONE},       // ignored item
        '{1'b0, CMD_UNUSE, 32'hFFFF_FFFF, 1'b1, ST_REFRESHED},  // release
        '{1'b0, CMD_UNUSE, 32'hFFFF_FFFF, 1'b1, ST_NOTFOUND},
        '{1'b0, CMD_USE,   32'h5A5A_5A5A, 1'b1, ST_ADDED},      // reuses freed slot
        '{1'b0, CMD_USE,   32'h1234_5678, 1'b0, ST_DONE},
        '{1'b0, CMD_TICK,  32'h0000_0000, 1'b0, ST_DONE},
        '{1'b1, CMD_USE,   32'h0000_FFFF, 1'b0, ST_DONE},       // largest timeout
        '{1'b0, CMD_TICK,  32'h0000_0000, 1'b1, ST_DONE},
        '{1'b1, CMD_USE,   32'h0000_0002, 1'b0, ST_DONE},
        '{1'b0, CMD_TICK,  32'h0000_0000, 1'b0, ST_DONE},       // several expire
        '{1'b0, CMD_TICK,  32'h0000_0000, 1'b0, ST_DONE},
        '{1'b0, CMD_USE,   32'hDEAD_BEEF, 1'b0, ST_DONE},
        '{1'b0, CMD_TICK,  32'h0000_0000, 1'b0, ST_DONE},
        '{1'b0, CMD_TICK,  32'h0000_0000, 1'b0, ST_DONE},       // a single expiry
        '{1'b1, CMD_USE,   32'h0000_0000, 1'b0, ST_DONE},
        '{1'b0, CMD_NONE,  32'hFFFF_FFFF, 1'b0, ST_DONE}
    };

    // random phases: first fills the table past capacity with expiry held
    // off, then a one-tick timeout drains it in a single scan
    logic [TIMEOUT_W-1:0] phase_timeout [NUM_PHASES] = '{16'hFFFF, 16'd1, 16'd3, 16'd6, 16'd0};
    int                   phase_items   [NUM_PHASES] = '{50, 35, 35, 35, 35};

    initial
    begin
        int r;
        int use_pct;
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] k;

        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_stamp[i] = '0;
        end
        foreach (key_pool[i])
            key_pool[i] = $urandom();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_timeout(dir_rows[i].k[TIMEOUT_W-1:0]);
            else
                send_item(dir_rows[i].op, dir_rows[i].k, dir_rows[i].typed, dir_rows[i].st);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_timeout(phase_timeout[p]);
            // no idling in the closing phase
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            use_pct = (p == 0) ? 80 : 55;
            for (int n = 0; n < phase_items[p]; )
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = CMD_NONE;
                else if (r < use_pct)
                    op = CMD_USE;
                else if (r < use_pct + 15)
                    op = CMD_UNUSE;
                else
                    op = CMD_TICK;
                // the filling phase walks the pool so the table overflows
                if (p == 0 && op == CMD_USE)
                begin
                    k = key_pool[fill_idx % KEY_POOL];
                    fill_idx++;
                end
                else if ($urandom_range(0, 9) == 0)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(0, KEY_POOL - 1)];
                send_item(op, k, 1'b0, ST_DONE);
                if (op != CMD_NONE)
                    n++;
            end
        end

        wait_quiet();

        $display("%0d items sent, %0d results checked: %0d expired, %0d table full",
                 items_sent, results_seen, expired_seen, full_seen);
        $display("timeouts swept from 0 to 65535, table overflowed and drained by scans");
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
